[hdl/bsc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared widths, codes and controller/datapath interface types for the
// uniform B-spline curve evaluator.
// ----------------------------------------------------------------------------
package bsc_pkg;

  localparam int MAX_POINTS = 64;
  localparam int PTS_AW     = 6;
  localparam int DEG_W      = 3;
  localparam int CNT_W      = 7;
  localparam int T_W        = 24;
  localparam int FRAC_W     = 16;
  localparam int COORD_W    = 32;
  localparam int BASIS_W    = 17;   // Q1.16, 65536 is one
  localparam int NUM_W      = 37;   // triangle numerator, Q32
  localparam int QN_W       = 21;   // numerator after dropping 16 fraction bits
  localparam int RECIP_W    = 25;
  localparam int RECIP_SH   = 24;
  localparam int QPROD_W    = QN_W + RECIP_W;
  localparam int MUL_W      = 50;   // signed coord times unsigned basis
  localparam int ACC_W      = 52;

  localparam logic [BASIS_W-1:0] ONE_Q16 = 17'h10000;

  // Item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  // Register indexes
  localparam logic CFG_DEGREE = 1'b0;
  localparam logic CFG_COUNT  = 1'b1;

  localparam logic [DEG_W-1:0] DEGREE_RST = 3'd3;
  localparam logic [CNT_W-1:0] COUNT_RST  = 7'd4;
  localparam logic [CNT_W-1:0] COUNT_MAX  = 7'd64;

  // Controller to datapath
  typedef struct packed {
    logic             load_pt;
    logic             start_eval;
    logic             tri_rd;
    logic             tri_mul;
    logic             tri_div;
    logic             tri_wr;
    logic             sum_rd;
    logic             sum_mul;
    logic             sum_acc;
    logic             out_load;
    logic [DEG_W-1:0] q;
    logic [DEG_W-1:0] m;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [DEG_W-1:0] deg;
    logic             no_support;
    logic             out_full;
  } status_t;

  // ceil(2^24 / q): exact floor division by q for numerators below 2^21
  function automatic logic [RECIP_W-1:0] recip(input logic [DEG_W-1:0] q);
    logic [RECIP_W-1:0] r;
    case (q)
      3'd1:    r = 25'd16777216;
      3'd2:    r = 25'd8388608;
      3'd3:    r = 25'd5592406;
      3'd4:    r = 25'd4194304;
      3'd5:    r = 25'd3355444;
      3'd6:    r = 25'd2796203;
      3'd7:    r = 25'd2396746;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[hdl/bsc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_ctrl
// Sequencer: walks the basis triangle entry by entry, then the weighted sum,
// then loads the output register; outside the support it only loads it.
// ----------------------------------------------------------------------------
module bsc_ctrl import bsc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_kind,
  output logic    in_ready,
  input  status_t sts,
  output cmd_t    cmd
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_TRD  = 9'b000000010,
    S_TMUL = 9'b000000100,
    S_TDIV = 9'b000001000,
    S_TWR  = 9'b000010000,
    S_SRD  = 9'b000100000,
    S_SMUL = 9'b001000000,
    S_SACC = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_t;

  state_t           state, state_next;
  logic [DEG_W-1:0] q, q_next;
  logic [DEG_W-1:0] m, m_next;

  // Next state and commands
  always_comb begin
    state_next = state;
    q_next     = q;
    m_next     = m;
    cmd        = '0;
    cmd.q      = q;
    cmd.m      = m;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_kind == KIND_LOAD) begin
            cmd.load_pt = 1'b1;
          end else begin
            cmd.start_eval = 1'b1;
            if (sts.no_support) begin
              state_next = S_FIN;
            end else if (sts.deg == '0) begin
              m_next     = '0;
              state_next = S_SRD;
            end else begin
              q_next     = 3'd1;
              m_next     = 3'd1;
              state_next = S_TRD;
            end
          end
        end
      end
      S_TRD: begin
        cmd.tri_rd = 1'b1;
        state_next = S_TMUL;
      end
      S_TMUL: begin
        cmd.tri_mul = 1'b1;
        state_next  = S_TDIV;
      end
      S_TDIV: begin
        cmd.tri_div = 1'b1;
        state_next  = S_TWR;
      end
      S_TWR: begin
        cmd.tri_wr = 1'b1;
        if (m != '0) begin
          m_next     = m - 3'd1;
          state_next = S_TRD;
        end else if (q == sts.deg) begin
          m_next     = '0;
          state_next = S_SRD;
        end else begin
          q_next     = q + 3'd1;
          m_next     = q + 3'd1;
          state_next = S_TRD;
        end
      end
      S_SRD: begin
        cmd.sum_rd = 1'b1;
        state_next = S_SMUL;
      end
      S_SMUL: begin
        cmd.sum_mul = 1'b1;
        state_next  = S_SACC;
      end
      S_SACC: begin
        cmd.sum_acc = 1'b1;
        if (m == sts.deg) begin
          state_next = S_FIN;
        end else begin
          m_next     = m + 3'd1;
          state_next = S_SRD;
        end
      end
      S_FIN: begin
        if (!sts.out_full) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      q     <= '0;
      m     <= '0;
    end else begin
      state <= state_next;
      q     <= q_next;
      m     <= m_next;
    end
  end

  assign in_ready = (state == S_IDLE);

endmodule

[hdl/bsc_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_datapath
// Point store, basis scratch, triangle arithmetic, multiply-accumulate,
// saturation, configuration registers and the output register.
// ----------------------------------------------------------------------------
module bsc_datapath import bsc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  cmd_t                      cmd,
  output status_t                   sts,
  input  logic [PTS_AW-1:0]         point_index,
  input  logic signed [COORD_W-1:0] point_x,
  input  logic signed [COORD_W-1:0] point_y,
  input  logic [T_W-1:0]            eval_param,
  input  logic                      cfg_valid,
  input  logic                      cfg_index,
  input  logic [CNT_W-1:0]          cfg_data,
  output logic signed [COORD_W-1:0] curve_x,
  output logic signed [COORD_W-1:0] curve_y,
  output logic                      out_valid,
  input  logic                      out_ready
);

  logic [DEG_W-1:0]            degree;
  logic [CNT_W-1:0]            point_count;
  logic [CNT_W-1:0]            cnt;
  logic [7:0]                  t_int;
  logic [FRAC_W-1:0]           t_frac;

  logic [COORD_W-1:0]          x_mem [MAX_POINTS];
  logic [COORD_W-1:0]          y_mem [MAX_POINTS];
  logic [BASIS_W-1:0]          b_mem [8];

  logic [BASIS_W-1:0]          bl, br, bs;
  logic [18:0]                 left, right;
  logic [35:0]                 pl, pr;
  logic [NUM_W-1:0]            num;
  logic [QPROD_W-1:0]          qprod;
  logic [QN_W:0]               qv;
  logic [BASIS_W-1:0]          wval;

  logic signed [9:0]           idx;
  logic                        idx_ok, svld;
  logic signed [COORD_W-1:0]   px, py;
  logic signed [MUL_W-1:0]     mx, my;
  logic signed [ACC_W-1:0]     accx, accy;

  // Floor to Q16.16 and clamp to 32 bits
  function automatic logic [COORD_W-1:0] sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-FRAC_W-1:0] h;
    logic [COORD_W-1:0]             r;
    h = a[ACC_W-1:FRAC_W];
    if (h > 36'sh07FFFFFFF)       r = 32'h7FFFFFFF;
    else if (h < -36'sh080000000) r = 32'h80000000;
    else                          r = h[COORD_W-1:0];
    return r;
  endfunction

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      degree      <= DEGREE_RST;
      point_count <= COUNT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DEGREE: degree      <= cfg_data[DEG_W-1:0];
        CFG_COUNT:  point_count <= cfg_data;
        default:    ;
      endcase
    end
  end

  assign cnt = (point_count > COUNT_MAX) ? COUNT_MAX : point_count;

  // Support check on the live parameter (used at accept)
  assign sts.deg        = degree;
  assign sts.no_support = (eval_param[T_W-1:FRAC_W] == 8'd0) || (cnt == '0) ||
                          ({1'b0, eval_param[T_W-1:FRAC_W]} >
                           ({2'b0, cnt} + {6'b0, degree}));
  assign sts.out_full   = out_valid && !out_ready;

  // Parameter latch
  always_ff @(posedge clk) begin
    if (cmd.start_eval) begin
      t_int  <= eval_param[T_W-1:FRAC_W];
      t_frac <= eval_param[FRAC_W-1:0];
    end
  end

  // Point store
  always_ff @(posedge clk) begin
    if (cmd.load_pt) begin
      x_mem[point_index] <= point_x;
      y_mem[point_index] <= point_y;
    end
    if (cmd.sum_rd) begin
      px <= x_mem[idx[PTS_AW-1:0]];
      py <= y_mem[idx[PTS_AW-1:0]];
    end
  end

  // Basis scratch: two read ports, one write port
  always_ff @(posedge clk) begin
    if (cmd.start_eval)  b_mem[0]     <= ONE_Q16;
    else if (cmd.tri_wr) b_mem[cmd.m] <= wval;
    if (cmd.tri_rd) begin
      bl <= b_mem[cmd.m - 3'd1];
      br <= b_mem[cmd.m];
    end
    if (cmd.sum_rd) bs <= b_mem[cmd.m];
  end

  // Triangle step: distances to the knots are frac-based
  assign left  = {cmd.q - cmd.m, t_frac};
  assign right = {cmd.m + 3'd1, 16'd0} - {3'd0, t_frac};
  assign pl    = (cmd.m != '0)   ? left * bl  : '0;
  assign pr    = (cmd.m < cmd.q) ? right * br : '0;

  // Divide by q through a reciprocal, cap at one
  assign qv   = qprod[QPROD_W-1:RECIP_SH];
  assign wval = (qv > {5'd0, ONE_Q16}) ? ONE_Q16 : qv[BASIS_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.tri_mul) num   <= {1'b0, pl} + {1'b0, pr};
    if (cmd.tri_div) qprod <= num[NUM_W-1:FRAC_W] * recip(cmd.q);
  end

  // Weighted sum over the span's points
  assign idx    = $signed({2'b0, t_int}) - 10'sd1 - $signed({7'd0, degree})
                  + $signed({7'd0, cmd.m});
  assign idx_ok = !idx[9] && (idx < $signed({3'd0, cnt}));

  always_ff @(posedge clk) begin
    if (cmd.sum_rd) svld <= idx_ok;
    if (cmd.sum_mul) begin
      mx <= svld ? px * $signed({1'b0, bs}) : $signed(MUL_W'(0));
      my <= svld ? py * $signed({1'b0, bs}) : $signed(MUL_W'(0));
    end
    if (cmd.start_eval) begin
      accx <= '0;
      accy <= '0;
    end else if (cmd.sum_acc) begin
      accx <= accx + {{(ACC_W-MUL_W){mx[MUL_W-1]}}, mx};
      accy <= accy + {{(ACC_W-MUL_W){my[MUL_W-1]}}, my};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      curve_x <= sat(accx);
      curve_y <= sat(accy);
    end
  end

endmodule

[hdl/bspline_curve_evaluator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bspline_curve_evaluator_unit
// Uniform B-spline curve evaluator of degree 0 to 7, fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): kind selects a load transaction, which
//   writes point_x/point_y into slot point_index, or an evaluate transaction,
//   which evaluates the curve at eval_param (unsigned Q8.16).
//   Output channel (out_valid/out_ready): one curve_x/curve_y transaction per
//   evaluate, none per load.
//   Config channel (cfg_valid/cfg_ready, always ready): index 0 degree,
//   index 1 point_count; write only while idle.
// Sequence:
//   A load is written when accepted. An evaluate walks the basis triangle,
//   T = degree*(degree+3)/2 entries, each a four-step pass through the
//   scratch read, product, reciprocal multiply and write, then reads,
//   multiplies and accumulates each of the degree+1 points; outside the
//   support it skips both. One item at a time; the next input is taken
//   once the result is in the output register.
// Reset: degree 3, point count 4, output empty. Point store is not cleared.
// Stall: loads proceed while a result is held; the next evaluate runs, then
//   waits with its result, holding off the input until the output drains.
// ----------------------------------------------------------------------------
module bspline_curve_evaluator_unit import bsc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      kind,
  input  logic [PTS_AW-1:0]         point_index,
  input  logic signed [COORD_W-1:0] point_x,
  input  logic signed [COORD_W-1:0] point_y,
  input  logic [T_W-1:0]            eval_param,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [COORD_W-1:0] curve_x,
  output logic signed [COORD_W-1:0] curve_y,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_index,
  input  logic [CNT_W-1:0]          cfg_data
);

  cmd_t    cmd;
  status_t sts;

  assign cfg_ready = 1'b1;

  bsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_kind  (kind),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bsc_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .point_index (point_index),
    .point_x     (point_x),
    .point_y     (point_y),
    .eval_param  (eval_param),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .curve_x     (curve_x),
    .curve_y     (curve_y),
    .out_valid   (out_valid),
    .out_ready   (out_ready)
  );

  // A load transaction leaves the block ready again
  a_load_returns: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && kind == KIND_LOAD |=> in_ready)
    else $error("load did not return to idle");

  // An evaluate transaction holds off the input channel
  a_eval_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && kind == KIND_EVAL |=> !in_ready)
    else $error("input accepted during evaluation");

  // A result appears only on the controller's load command
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("result without load command");

endmodule

[sim/bspline_curve_evaluator_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bspline_curve_evaluator_unit_tb
// Self-checking bench for the B-spline curve evaluator. A scoreboard class
// keeps its own copy of the point store and registers, predicts each
// evaluate transaction bit-exactly and compares it with the output channel.
// Stimulus covers directed corners, then randomized phases over many
// degree/point-count settings with random idling on both channels.
// ----------------------------------------------------------------------------
module bspline_curve_evaluator_unit_tb;
  import bsc_pkg::*;

  typedef struct {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
  } curve_pt_t;

  // Curve predictor plus store of expected curve points
  class curve_scoreboard;
    logic [COORD_W-1:0] xs[MAX_POINTS];
    logic [COORD_W-1:0] ys[MAX_POINTS];
    bit                 loaded[MAX_POINTS];
    logic [DEG_W-1:0]   deg_reg;
    logic [CNT_W-1:0]   cnt_reg;
    curve_pt_t          want_q[$];
    int                 errors;

    function new();
      deg_reg = DEGREE_RST;
      cnt_reg = COUNT_RST;
      errors  = 0;
      foreach (loaded[i]) loaded[i] = 0;
    endfunction

    function void write_reg(logic idx, logic [CNT_W-1:0] data);
      if (idx == CFG_DEGREE) deg_reg = data[DEG_W-1:0];
      else cnt_reg = data;
    endfunction

    function int eff_cnt();
      return (cnt_reg > COUNT_MAX) ? MAX_POINTS : int'(cnt_reg);
    endfunction

    // First slot an evaluate at t would read that holds no point, else -1
    function int missing_slot(logic [T_W-1:0] t);
      int s;
      int cnt;
      s   = int'(t >> FRAC_W) - 1;
      cnt = eff_cnt();
      if (s < 0 || cnt == 0 || s > cnt + int'(deg_reg) - 1) return -1;
      for (int i = s - int'(deg_reg); i <= s; i++)
        if (i >= 0 && i < cnt && !loaded[i]) return i;
      return -1;
    endfunction

    function logic [COORD_W-1:0] to_q16_sat(longint acc);
      longint v;
      v = acc >>> FRAC_W;
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[COORD_W-1:0];
    endfunction

    // Accepted input transaction: update store or predict curve point
    function void note_item(logic k, logic [PTS_AW-1:0] idx, logic [COORD_W-1:0] x,
                            logic [COORD_W-1:0] y, logic [T_W-1:0] t);
      longint unsigned basis[8];
      longint unsigned num;
      longint          s, i, left, right, sx, sy, tt;
      int              deg, cnt;
      curve_pt_t       r;
      if (k == KIND_LOAD) begin
        xs[idx] = x;
        ys[idx] = y;
        loaded[idx] = 1;
        return;
      end
      deg = int'(deg_reg);
      cnt = eff_cnt();
      tt  = longint'(t);
      s   = (tt >> FRAC_W) - 1;
      r.cx = '0;
      r.cy = '0;
      if (!(s < 0 || cnt == 0 || s > cnt + deg - 1)) begin
        foreach (basis[j]) basis[j] = 0;
        basis[0] = 65536;
        for (int q = 1; q <= deg; q++) begin
          for (int m = q; m >= 0; m--) begin
            i   = s - q + m;
            num = 0;
            if (m >= 1) begin
              left = tt - (i + 1) * 65536;
              if (left > 0) num += longint'(left) * basis[m-1];
            end
            if (m < q) begin
              right = (i + q + 2) * 65536 - tt;
              if (right > 0) num += longint'(right) * basis[m];
            end
            num = num / (longint'(q) * 65536);
            basis[m] = (num > 65536) ? 65536 : num;
          end
        end
        sx = 0;
        sy = 0;
        for (int m = 0; m <= deg; m++) begin
          i = s - deg + m;
          if (i >= 0 && i < cnt) begin
            sx += longint'($signed(xs[i])) * longint'(basis[m]);
            sy += longint'($signed(ys[i])) * longint'(basis[m]);
          end
        end
        r.cx = to_q16_sat(sx);
        r.cy = to_q16_sat(sy);
      end
      want_q = {want_q, r};
    endfunction

    task report_mismatch(string what, logic [COORD_W-1:0] got, logic [COORD_W-1:0] exp);
      errors++;
      $display("[%0t] %s: got %h, expected %h", $realtime, what, got, exp);
    endtask

    // Accepted output transaction
    task check_point(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy);
      curve_pt_t e;
      if (want_q.size() == 0) begin
        report_mismatch("unexpected curve point", cx, '0);
        return;
      end
      e = want_q.pop_front();
      if (cx !== e.cx) report_mismatch("curve_x", cx, e.cx);
      if (cy !== e.cy) report_mismatch("curve_y", cy, e.cy);
    endtask
  endclass

  logic                      clk = 0;
  logic                      rst = 1;
  logic                      in_valid = 0;
  logic                      in_ready;
  logic                      kind = KIND_LOAD;
  logic [PTS_AW-1:0]         point_index = '0;
  logic signed [COORD_W-1:0] point_x = '0;
  logic signed [COORD_W-1:0] point_y = '0;
  logic [T_W-1:0]            eval_param = '0;
  logic                      out_valid;
  logic                      out_ready = 0;
  logic signed [COORD_W-1:0] curve_x;
  logic signed [COORD_W-1:0] curve_y;
  logic                      cfg_valid = 0;
  logic                      cfg_ready;
  logic                      cfg_index = CFG_DEGREE;
  logic [CNT_W-1:0]          cfg_data = '0;

  bit              calm = 0;   // no idling on either side while set
  curve_scoreboard sb = new();

  bspline_curve_evaluator_unit u_dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Output side: random back-pressure, checks at rising edge
  always @(negedge clk) out_ready <= calm || ($urandom_range(99) >= 31);

  always @(posedge clk)
    if (!rst && out_valid && out_ready) sb.check_point(curve_x, curve_y);

  // One input transaction, valid held until accepted
  task send_item(logic k, logic [PTS_AW-1:0] idx, logic [COORD_W-1:0] x,
                 logic [COORD_W-1:0] y, logic [T_W-1:0] t);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 31) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid    <= 1;
    kind        <= k;
    point_index <= idx;
    point_x     <= x;
    point_y     <= y;
    eval_param  <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(k, idx, x, y, t);
  endtask

  // Evaluate, loading any point it would need first
  task send_eval(logic [T_W-1:0] t);
    int miss;
    miss = sb.missing_slot(t);
    while (miss >= 0) begin
      send_item(KIND_LOAD, miss[PTS_AW-1:0], $urandom, $urandom, '0);
      miss = sb.missing_slot(t);
    end
    send_item(KIND_EVAL, '0, '0, '0, t);
  endtask

  // Wait for all results, then let a trailing load finish
  task drain();
    @(negedge clk);
    in_valid <= 0;
    while (sb.want_q.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task write_cfg(logic idx, logic [CNT_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  function logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(15))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '0;
      3:       return $urandom_range(8) << 16;
      default: return $urandom;
    endcase
  endfunction

  // Parameter mostly inside the support, sometimes anywhere
  function logic [T_W-1:0] rand_param();
    int top;
    top = sb.eff_cnt() + int'(sb.deg_reg);
    if ($urandom_range(9) == 0) return T_W'($urandom);
    return T_W'(((longint'($urandom_range(top)) + 1) << FRAC_W) | $urandom_range(16'hFFFF));
  endfunction

  initial begin
    int degs[10] = '{0, 1, 2, 3, 4, 5, 6, 7, 7, 2};
    int cnts[10] = '{1, 64, 5, 127, 17, 2, 40, 64, 1, 9};
    int n;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed corners at reset settings (degree 3, four points)
    send_item(KIND_LOAD, 6'd0, 32'h7FFF_FFFF, 32'h8000_0000, '0);
    send_item(KIND_LOAD, 6'd1, 32'h7FFF_FFFF, 32'h8000_0000, '0);
    send_item(KIND_LOAD, 6'd2, 32'h7FFF_FFFF, 32'h8000_0000, '0);
    send_item(KIND_LOAD, 6'd3, 32'h0001_0000, 32'hFFFF_FFFF, '0);
    send_item(KIND_LOAD, 6'd63, 32'hFFFF_FFFF, 32'h0000_0001, '0);
    send_eval(24'h00_0000);   // below first knot
    send_eval(24'h00_FFFF);
    send_eval(24'h01_0000);   // first knot
    send_eval(24'h04_0000);   // sum near full scale
    send_eval(24'h04_8000);
    send_eval(24'h07_FFFF);   // last span
    send_eval(24'h08_0000);   // past support
    send_eval(24'hFF_FFFF);
    drain();
    // Point count zero, then above the store size
    write_cfg(CFG_COUNT, 7'd0);
    send_eval(24'h02_8000);
    drain();
    write_cfg(CFG_COUNT, 7'd127);
    write_cfg(CFG_DEGREE, 7'd7);
    send_eval(24'h45_8000);
    send_eval(24'h47_FFFF);
    drain();

    // Randomized phases
    for (int ph = 0; ph < 10; ph++) begin
      write_cfg(CFG_DEGREE, degs[ph][CNT_W-1:0]);
      write_cfg(CFG_COUNT, cnts[ph][CNT_W-1:0]);
      n = 0;
      while (n < 160) begin
        calm = (ph == 4 && n >= 40 && n < 120);
        if (ph == 2 && n == 80) drain();
        if ($urandom_range(2) == 0)
          send_item(KIND_LOAD, PTS_AW'($urandom), rand_coord(), rand_coord(),
                    T_W'($urandom));
        else
          send_eval(rand_param());
        n++;
      end
      calm = 0;
      drain();
    end

    if (sb.errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Run limit
  initial begin
    #40ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
